// ----- design/sdiv_pkg.sv -----
// shared widths and controller/datapath interface types for the signed 128-bit divider
package sdiv_pkg;

  localparam int HALF_W  = 64;
  localparam int WORD_W  = 2 * HALF_W;
  localparam int TDATA_W = 4 * HALF_W;
  localparam int CNT_W   = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

  typedef struct packed {
    logic load;
    logic neg;
    logic step;
    logic fix;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic divisor_zero;
  } sts_t;

endpackage

// ----- design/sdiv_ctrl.sv -----
// sequencing state machine and stream handshakes for the signed 128-bit divider
module sdiv_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sdiv_pkg::cmd_t cmd,
  input  sdiv_pkg::sts_t sts
);
  import sdiv_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NEG  = 3'd1;
  localparam logic [2:0] ST_ITER = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign in_ready = (state == ST_IDLE);
  // output register may be refilled when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.neg     = 1'b0;
    cmd.step    = 1'b0;
    cmd.fix     = 1'b0;
    cmd.publish = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_NEG;
        end
      end
      ST_NEG: begin
        cmd.neg    = 1'b1;
        state_next = sts.divisor_zero ? ST_FIX : ST_ITER;
      end
      ST_ITER: begin
        cmd.step = 1'b1;
        if (cnt == LAST_STEP) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ITER) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_iter_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER && cnt == LAST_STEP) |=> state == ST_FIX)
    else $error("iteration did not end after the last step");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ITER) |=> (state != ST_ITER || cnt == '0))
    else $error("step counter not cleared on entry to iteration");

  a_publish: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> (out_valid && state == ST_IDLE))
    else $error("published result not presented");

endmodule

// ----- design/sdiv_dp.sv -----
// operand, quotient and remainder registers with the restoring division step
module sdiv_dp (
  input  logic                          clk,
  input  sdiv_pkg::cmd_t                cmd,
  output sdiv_pkg::sts_t                sts,
  input  logic [sdiv_pkg::WORD_W-1:0]   dividend,
  input  logic [sdiv_pkg::WORD_W-1:0]   divisor,
  output logic [sdiv_pkg::WORD_W-1:0]   quotient,
  output logic [sdiv_pkg::WORD_W-1:0]   remainder,
  output logic                          status
);
  import sdiv_pkg::*;

  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dvs;
  logic              a_neg;
  logic              b_neg;
  logic              dz;

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] diff;
  logic              take;

  assign sts.divisor_zero = (dvs == '0);

  // shift in the next dividend bit, then trial subtract
  assign rem_sh = {rem, quo[WORD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign take   = !diff[WORD_W+1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo   <= dividend;
      dvs   <= divisor;
      a_neg <= dividend[WORD_W-1];
      b_neg <= divisor[WORD_W-1];
    end else if (cmd.neg) begin
      rem <= '0;
      dz  <= sts.divisor_zero;
      if (sts.divisor_zero) begin
        quo   <= '0;
        a_neg <= 1'b0;
        b_neg <= 1'b0;
      end else begin
        quo <= a_neg ? (~quo + 1'b1) : quo;
        dvs <= b_neg ? (~dvs + 1'b1) : dvs;
      end
    end else if (cmd.step) begin
      rem <= take ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], take};
    end else if (cmd.fix) begin
      quo <= (a_neg ^ b_neg) ? (~quo + 1'b1) : quo;
      rem <= a_neg ? (~rem + 1'b1) : rem;
    end
    if (cmd.publish) begin
      quotient  <= quo;
      remainder <= rem;
      status    <= dz;
    end
  end

  a_zero_result: assert property (@(posedge clk)
    (cmd.publish && dz) |-> (quo == '0 && rem == '0))
    else $error("divide by zero result not cleared");

endmodule

// ----- design/signed_128bit_divider_top.sv -----
// signed 128-bit divider top level: stream ports, controller and datapath
// the controller takes each transaction through load, operand sign fix-up, the 128 restoring
// steps of the single shared subtractor, result sign fix-up and publish; a zero divisor
// skips the steps, and a new transaction is accepted only after the last one is published
// reset: synchronous, active high; clears the controller and drops output valid
module signed_128bit_divider_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // dividend_hi, dividend_lo, divisor_hi, divisor_lo
  input  logic [sdiv_pkg::TDATA_W-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // quotient_hi, quotient_lo, remainder_hi, remainder_lo
  output logic [sdiv_pkg::TDATA_W-1:0]   m_axis_tdata,
  // status
  output logic                           m_axis_tuser
);
  import sdiv_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [WORD_W-1:0] dividend;
  logic [WORD_W-1:0] divisor;
  logic [WORD_W-1:0] quotient;
  logic [WORD_W-1:0] remainder;

  assign dividend = {s_axis_tdata[HALF_W-1:0], s_axis_tdata[2*HALF_W-1:HALF_W]};
  assign divisor  = {s_axis_tdata[3*HALF_W-1:2*HALF_W], s_axis_tdata[4*HALF_W-1:3*HALF_W]};

  assign m_axis_tdata = {remainder[HALF_W-1:0], remainder[WORD_W-1:HALF_W],
                         quotient[HALF_W-1:0], quotient[WORD_W-1:HALF_W]};

  sdiv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sdiv_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (m_axis_tuser)
  );

endmodule

// ----- verif/signed_128bit_divider_checker.sv -----
// checker for the signed 128-bit divider: predicts quotient, remainder and status per transaction
`timescale 1ns / 100ps

module signed_128bit_divider_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  // dividend_hi, dividend_lo, divisor_hi, divisor_lo
  input  logic [sdiv_pkg::TDATA_W-1:0] s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // quotient_hi, quotient_lo, remainder_hi, remainder_lo
  input  logic [sdiv_pkg::TDATA_W-1:0] m_axis_tdata,
  // status
  input  logic                         m_axis_tuser,
  output int                           mismatch_count,
  output int                           awaited_count
);

  localparam int HW = sdiv_pkg::HALF_W;

  typedef struct packed {
    logic [HW-1:0] quotient_hi;
    logic [HW-1:0] quotient_lo;
    logic [HW-1:0] remainder_hi;
    logic [HW-1:0] remainder_lo;
    logic          status;
  } div_result_t;

  div_result_t awaited_results[$];

  // truncating signed division done on magnitudes, signs applied afterwards
  function automatic div_result_t signed_divide(logic [2*HW-1:0] num, logic [2*HW-1:0] den);
    div_result_t   res;
    logic [2*HW-1:0] num_mag;
    logic [2*HW-1:0] den_mag;
    logic [2*HW-1:0] quo;
    logic [2*HW-1:0] rem;
    res = '0;
    if (den == '0) begin
      res.status = 1'b1;
      return res;
    end
    num_mag = num[2*HW-1] ? ~num + 1'b1 : num;
    den_mag = den[2*HW-1] ? ~den + 1'b1 : den;
    quo = num_mag / den_mag;
    rem = num_mag % den_mag;
    if (num[2*HW-1] ^ den[2*HW-1]) quo = ~quo + 1'b1;
    if (num[2*HW-1]) rem = ~rem + 1'b1;
    res.quotient_hi  = quo[2*HW-1:HW];
    res.quotient_lo  = quo[HW-1:0];
    res.remainder_hi = rem[2*HW-1:HW];
    res.remainder_lo = rem[HW-1:0];
    return res;
  endfunction

  function automatic int compare_field(string name, logic [HW-1:0] want, logic [HW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  initial mismatch_count = 0;
  assign awaited_count = awaited_results.size();

  always @(posedge clk) begin
    div_result_t want;
    div_result_t got;
    int          errs;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(signed_divide(
          {s_axis_tdata[HW-1:0], s_axis_tdata[2*HW-1:HW]},
          {s_axis_tdata[3*HW-1:2*HW], s_axis_tdata[4*HW-1:3*HW]}));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.quotient_hi  = m_axis_tdata[HW-1:0];
        got.quotient_lo  = m_axis_tdata[2*HW-1:HW];
        got.remainder_hi = m_axis_tdata[3*HW-1:2*HW];
        got.remainder_lo = m_axis_tdata[4*HW-1:3*HW];
        got.status       = m_axis_tuser;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none actual %h status %b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = awaited_results.pop_front();
          errs = compare_field("quotient_hi", want.quotient_hi, got.quotient_hi)
               + compare_field("quotient_lo", want.quotient_lo, got.quotient_lo)
               + compare_field("remainder_hi", want.remainder_hi, got.remainder_hi)
               + compare_field("remainder_lo", want.remainder_lo, got.remainder_lo)
               + compare_field("status", HW'(want.status), HW'(got.status));
          if (errs != 0) mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

endmodule

// ----- verif/tb_signed_128bit_divider_top.sv -----
// testbench top for the signed 128-bit divider: stimulus, back-pressure and verdict
`timescale 1ns / 100ps

module tb_signed_128bit_divider_top;

  localparam int HW        = sdiv_pkg::HALF_W;
  localparam int N_RANDOM  = 1100;
  localparam logic [2*HW-1:0] MOST_NEG = {1'b1, {(2*HW-1){1'b0}}};
  localparam logic [2*HW-1:0] MOST_POS = {1'b0, {(2*HW-1){1'b1}}};
  localparam logic [2*HW-1:0] MINUS_ONE = {(2*HW){1'b1}};

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [sdiv_pkg::TDATA_W-1:0] s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [sdiv_pkg::TDATA_W-1:0] m_axis_tdata;
  logic                         m_axis_tuser;

  int   mismatch_count;
  int   awaited_count;
  logic calm = 1'b0;
  int   stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  signed_128bit_divider_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  signed_128bit_divider_checker quotient_check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  // result back-pressure in bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 18);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [2*HW-1:0] negate(logic [2*HW-1:0] v);
    return ~v + 1'b1;
  endfunction

  function automatic logic [2*HW-1:0] random_operand();
    logic [2*HW-1:0] raw;
    logic [2*HW-1:0] mag;
    raw = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 6))
      0: mag = raw;
      1: mag = raw >> HW;
      2: mag = raw >> (2*HW - 16);
      3: begin
        case ($urandom_range(0, 5))
          0: mag = '0;
          1: mag = 1;
          2: mag = MOST_NEG;
          3: mag = MOST_POS;
          4: mag = {{(HW-1){1'b0}}, 1'b1, {HW{1'b0}}};
          default: mag = {{HW{1'b0}}, {HW{1'b1}}};
        endcase
      end
      default: mag = raw >> $urandom_range(0, 2*HW - 1);
    endcase
    return $urandom_range(0, 1) ? negate(mag) : mag;
  endfunction

  // dividend and divisor go out high half of each field first: dividend_hi in the lowest bits
  task automatic send_division(logic [2*HW-1:0] dividend, logic [2*HW-1:0] divisor);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {divisor[HW-1:0], divisor[2*HW-1:HW], dividend[HW-1:0], dividend[2*HW-1:HW]};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin
    logic [2*HW-1:0] num;
    logic [2*HW-1:0] den;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_division(0, 1);
    send_division(1, 1);
    send_division(7, 2);
    send_division(negate(7), 2);
    send_division(7, negate(2));
    send_division(negate(7), negate(2));
    send_division(MOST_NEG, MINUS_ONE);
    send_division(MOST_NEG, 1);
    send_division(MOST_NEG, MOST_NEG);
    send_division(MOST_POS, MOST_NEG);
    send_division(MOST_POS, MOST_POS);
    send_division(MOST_POS, MINUS_ONE);
    send_division(0, 0);
    send_division(MOST_POS, 0);
    send_division(MOST_NEG, 0);
    send_division(MINUS_ONE, 0);
    send_division(3, 128'd1 << 100);
    send_division(negate(3), negate(128'd1 << 100));
    send_division(MINUS_ONE, MOST_POS);
    send_division(MOST_NEG, 128'd1 << HW);
    send_division({{HW{1'b0}}, {HW{1'b1}}}, (128'd1 << 32) + 1);
    send_division(MOST_POS, 3);
    send_division({$urandom, $urandom, $urandom, $urandom}, {{HW{1'b1}}, {HW{1'b0}}});

    for (int n = 0; n < N_RANDOM; n++) begin
      // quiet stretches, and a quiet tail
      calm <= (n >= N_RANDOM - 100) || ((n / 150) % 4 == 3);
      den = random_operand();
      case ($urandom_range(0, 9))
        0: den = '0;
        1: begin
          // exact multiple: remainder zero
          den = den >> $urandom_range(64, 127);
          if (den == '0) den = 1;
          num = den * ({$urandom, $urandom} >> $urandom_range(1, 63));
          num = $urandom_range(0, 1) ? negate(num) : num;
        end
        default: num = random_operand();
      endcase
      if (den != '0 && num == den && $urandom_range(0, 1)) num = num + 1'b1;
      send_division(num, den);
    end
    s_axis_tvalid <= 1'b0;

    while (awaited_count != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- signed_128bit_divider_top.f -----
design/sdiv_pkg.sv
design/sdiv_ctrl.sv
design/sdiv_dp.sv
design/signed_128bit_divider_top.sv
verif/signed_128bit_divider_checker.sv
verif/tb_signed_128bit_divider_top.sv
